>>> rtl/tpp_pkg.sv
`default_nettype none
package tpp_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // panel geometry
  localparam logic [5:0] MARGIN_LEFT  = 6'd2;
  localparam logic [5:0] MARGIN_RIGHT = 6'd62;
  localparam logic [5:0] CELL_W       = 6'd6;
  localparam int unsigned CELLS_PER_LINE = 10;
  localparam logic [2:0] BLANK_COL    = 3'd5;  // spacing column of a cell
  localparam logic [2:0] BLANK_ROW    = 3'd7;  // spacing row of a cell
  localparam int unsigned GLYPH_W     = 5;

  // x/6 == (x*43)>>8 for every x below 60
  localparam logic [5:0] RECIP6       = 6'd43;

  // character index: up to 8 lines of 10 cells
  localparam int unsigned IDX_W = 7;

  localparam logic [7:0] BAR_COL = 8'h5F;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [5:0] pixel_column;
    logic [4:0] half_row;
  } tpp_in_t;

  typedef struct packed {
    logic [15:0] top_pixel;
    logic [15:0] bottom_pixel;
    logic [10:0] frame_address;
  } tpp_out_t;

  // horizontal decode of a column, shared by both lanes
  typedef struct packed {
    logic       lit_ok;  // inside margins and not on the spacing column
    logic [3:0] cell_idx;
    logic [2:0] col;
  } tpp_cell_t;

  // pipeline control from the merge stage
  typedef struct packed {
    logic s1_valid;
    logic s1_adv;
  } tpp_pipe_t;

  typedef logic [0:GLYPH_W-1][7:0] glyph_t;

  function automatic glyph_t font_glyph(input logic [7:0] code);
    glyph_t g;
    unique case (code)
      8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};  // 0
      8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      8'h32: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      8'h33: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      8'h35: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      8'h36: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};  // 9
      8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};  // A
      8'h42: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      8'h46: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      8'h4A: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      8'h4E: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      8'h51: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      8'h53: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      8'h57: g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
      8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      8'h5A: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};  // Z
      8'h2B: g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};  // +
      8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};  // -
      8'h2A: g = {8'h22, 8'h14, 8'h7F, 8'h14, 8'h22};  // *
      8'h2F: g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};  // /
      8'h3D: g = {8'h14, 8'h14, 8'h14, 8'h14, 8'h14};  // =
      8'h3A: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};  // :
      8'h2E: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};  // .
      8'h3F: g = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};  // ?
      8'h20: g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};  // space
      default: g = {8'h00, 8'h00, BAR_COL, 8'h00, 8'h00};  // unknown: bar
    endcase
    return g;
  endfunction

  function automatic logic [7:0] glyph_byte(input logic [7:0] code, input logic [2:0] col);
    glyph_t     g;
    logic [7:0] b;
    g = font_glyph(code);
    unique case (col)
      3'd0: b = g[0];
      3'd1: b = g[1];
      3'd2: b = g[2];
      3'd3: b = g[3];
      3'd4: b = g[4];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/text_panel_pixel_renderer.sv
`default_nettype none
// channel | ports                          | payload
// --------+--------------------------------+----------------------------
// input   | in_valid, in_stall, in_item    | tpp_in_t (op, code, x, y)
// result  | out_valid, out_stall, out_item | tpp_out_t (top, bottom, addr)
// config  | cfg_valid, cfg_ready, cfg_data | text_color, 16 bit
//
// One item per clock sustained while in_stall is low. A query reads the text
// store (registered RAM) when it is accepted; the glyph lookup then lands in
// the result register as soon as that register is free or being taken.
// Clear and append items give no result.
// Synchronous active-low reset clears the text length, the color and all
// valid flags; no clearing pass. in_stall rises only while a query waits in
// the lookup stage and the result register is held by out_stall.
module text_panel_pixel_renderer #(
  parameter int TEXT_CAPACITY = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tpp_pkg::tpp_in_t   in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tpp_pkg::tpp_out_t       out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);
  import tpp_pkg::*;

  localparam int LW = $clog2(TEXT_CAPACITY + 1);
  localparam int AW = $clog2(TEXT_CAPACITY);

  logic          in_acc;
  logic          q_acc;
  logic          app_acc;
  logic          wr_en;
  logic [LW-1:0] len_r, len_nxt;
  logic [15:0]   color_r;
  tpp_pipe_t     pipe;
  tpp_cell_t     xdec;
  logic [5:0]    xo;
  logic [11:0]   prod;
  logic [5:0]    y_top, y_bot;
  logic [15:0]   top_px, bot_px;

  // Input is held back only when the lookup stage cannot drain.
  assign in_stall = pipe.s1_valid && out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign q_acc    = in_acc && (in_item.operation == OP_QUERY);
  assign app_acc  = in_acc && (in_item.operation == OP_APPEND);
  assign wr_en    = app_acc && (len_r < LW'(TEXT_CAPACITY));

  // text length: clear resets, append grows until full
  always_comb begin
    len_nxt = len_r;
    if (in_acc && (in_item.operation == OP_CLEAR)) begin
      len_nxt = '0;
    end else if (wr_en) begin
      len_nxt = len_r + LW'(1);
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      color_r <= 16'h0000;
    end else begin
      len_r <= len_nxt;
      if (cfg_valid) begin
        color_r <= cfg_data;
      end
    end
  end

  // Column decode, shared by both lanes: cell = (x-2)/6 by reciprocal.
  assign xo            = in_item.pixel_column - MARGIN_LEFT;
  assign prod          = {6'b0, xo} * {6'b0, RECIP6};
  assign xdec.cell_idx = prod[11:8];
  assign xdec.col      = 3'(xo - 6'({2'b00, xdec.cell_idx} * CELL_W));
  assign xdec.lit_ok   = (in_item.pixel_column >= MARGIN_LEFT) &&
                         (in_item.pixel_column < MARGIN_RIGHT) &&
                         (xdec.col != BLANK_COL);

  // top lane sees the row as given, bottom lane the row 32 lower
  assign y_top = {1'b0, in_item.half_row};
  assign y_bot = {1'b1, in_item.half_row};

  tpp_lane #(.TEXT_CAPACITY(TEXT_CAPACITY)) u_lane_top (
    .clk      (clk),
    .load     (q_acc),
    .cell_in  (xdec),
    .y        (y_top),
    .text_len (len_r),
    .wr_en    (wr_en),
    .wr_addr  (AW'(len_r)),
    .wr_data  (in_item.char_code),
    .color    (color_r),
    .pixel    (top_px)
  );

  tpp_lane #(.TEXT_CAPACITY(TEXT_CAPACITY)) u_lane_bot (
    .clk      (clk),
    .load     (q_acc),
    .cell_in  (xdec),
    .y        (y_bot),
    .text_len (len_r),
    .wr_en    (wr_en),
    .wr_addr  (AW'(len_r)),
    .wr_data  (in_item.char_code),
    .color    (color_r),
    .pixel    (bot_px)
  );

  tpp_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (q_acc),
    .addr_in   ({in_item.half_row, in_item.pixel_column}),
    .top_px    (top_px),
    .bot_px    (bot_px),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .pipe      (pipe)
  );

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(TEXT_CAPACITY))
    else $error("text length beyond capacity");

  a_query_enters: assert property (@(posedge clk) disable iff (!rst_n)
    q_acc |=> pipe.s1_valid)
    else $error("accepted query lost before lookup stage");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pipe.s1_valid))
    else $error("result appeared without a query in lookup stage");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe.s1_adv && out_valid) |-> !out_stall)
    else $error("lookup stage moved into a held result");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe.s1_valid && !pipe.s1_adv) |=> pipe.s1_valid)
    else $error("stalled lookup item dropped");

endmodule
`default_nettype wire

>>> rtl/tpp_ram.sv
`default_nettype none
module tpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/tpp_lane.sv
`default_nettype none
// One pixel lane: character index, text store copy, font lookup.
module tpp_lane #(
  parameter int TEXT_CAPACITY = 32
) (
  input  wire logic                                clk,
  input  wire logic                                load,    // query accepted
  input  wire tpp_pkg::tpp_cell_t                  cell_in,
  input  wire logic [5:0]                          y,
  input  wire logic [$clog2(TEXT_CAPACITY+1)-1:0] text_len,
  input  wire logic                                wr_en,
  input  wire logic [$clog2(TEXT_CAPACITY)-1:0]   wr_addr,
  input  wire logic [7:0]                          wr_data,
  input  wire logic [15:0]                         color,
  output logic      [15:0]                         pixel
);
  import tpp_pkg::*;

  localparam int LW = $clog2(TEXT_CAPACITY + 1);
  localparam int AW = $clog2(TEXT_CAPACITY);

  logic [2:0]       line;
  logic [2:0]       row;
  logic [IDX_W-1:0] idx;
  logic             vis;
  logic             vis_r;
  logic [2:0]       col_r;
  logic [2:0]       row_r;
  logic [7:0]       code;
  logic [7:0]       col_bits;

  assign line = y[5:3];
  assign row  = y[2:0];
  assign idx  = IDX_W'({4'b0, line} * IDX_W'(CELLS_PER_LINE)) + IDX_W'(cell_in.cell_idx);
  assign vis  = cell_in.lit_ok && (row != BLANK_ROW) &&
                ({{LW{1'b0}}, idx} < {{IDX_W{1'b0}}, text_len});

  always_ff @(posedge clk) begin
    if (load) begin
      vis_r <= vis;
      col_r <= cell_in.col;
      row_r <= row;
    end
  end

  tpp_ram #(.WIDTH(8), .DEPTH(TEXT_CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (load),
    .rd_addr (AW'(idx)),
    .rd_data (code)
  );

  assign col_bits = glyph_byte(code, col_r);
  assign pixel    = (vis_r && col_bits[row_r]) ? color : 16'h0000;

endmodule
`default_nettype wire

>>> rtl/tpp_merge.sv
`default_nettype none
// Joins both lane pixels with the word address into the result register.
module tpp_merge (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic [10:0]       addr_in,
  input  wire logic [15:0]       top_px,
  input  wire logic [15:0]       bot_px,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output tpp_pkg::tpp_out_t      out_item,
  output tpp_pkg::tpp_pipe_t     pipe
);
  import tpp_pkg::*;

  logic        s1_v_r, s1_v_nxt;
  logic        out_v_r, out_v_nxt;
  logic [10:0] addr_r;
  tpp_out_t    out_r;
  logic        adv;

  assign adv = s1_v_r && (!out_v_r || !out_stall);

  always_comb begin
    s1_v_nxt  = load ? 1'b1 : (adv ? 1'b0 : s1_v_r);
    out_v_nxt = adv ? 1'b1 : (out_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= addr_in;
    end
    if (adv) begin
      out_r.top_pixel     <= top_px;
      out_r.bottom_pixel  <= bot_px;
      out_r.frame_address <= addr_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_item      = out_r;
  assign pipe.s1_valid = s1_v_r;
  assign pipe.s1_adv   = adv;

endmodule
`default_nettype wire

>>> tb/text_panel_pixel_renderer_tb.sv
`timescale 1ns / 100ps

module text_panel_pixel_renderer_tb;
  import tpp_pkg::*;

  // op code the block ignores; the package has no name for it
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // panel geometry, kept apart from the RTL's own constants
  localparam int unsigned TEXT_CAP      = 32;
  localparam int unsigned LEFT_EDGE     = 2;
  localparam int unsigned RIGHT_EDGE    = 62;
  localparam int unsigned CELL_PITCH    = 6;
  localparam int unsigned LINE_PITCH    = 8;
  localparam int unsigned CELLS_PER_ROW = 10;
  localparam int unsigned GLYPH_COLS    = 5;
  localparam int unsigned GLYPH_ROWS    = 7;

  localparam int unsigned MAX_GAP      = 11;
  localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int unsigned DRAIN_SLACK  = 6;     // slack after the last pending result
  localparam int unsigned PHASES       = 5;
  localparam int unsigned TOTAL_ITEMS  = 1350;
  localparam int unsigned RUN_LIMIT_NS = 2000000;
  localparam int unsigned MAX_PRINTS   = 100;

  // predicts the pixel pairs from its own copy of the text and the ink color
  class panel_scoreboard;
    logic [15:0] ink;
    logic [7:0]  glyph_codes [TEXT_CAP];
    int unsigned text_len;
    tpp_out_t    pairs_due [$];
    int unsigned errors;

    function new();
      ink      = '0;
      text_len = 0;
      errors   = 0;
    endfunction

    function void set_ink(logic [15:0] c);
      ink = c;
    endfunction

    function int unsigned pending();
      return pairs_due.size();
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      errors++;
    endtask

    // column byte of the 5x7 font; bit n is glyph row n
    function logic [7:0] font_column(logic [7:0] code, int unsigned col);
      logic [39:0] cols;
      case (code)
        "0": cols = 40'h3E_51_49_45_3E;
        "1": cols = 40'h00_42_7F_40_00;
        "2": cols = 40'h42_61_51_49_46;
        "3": cols = 40'h21_41_45_4B_31;
        "4": cols = 40'h18_14_12_7F_10;
        "5": cols = 40'h27_45_45_45_39;
        "6": cols = 40'h3C_4A_49_49_30;
        "7": cols = 40'h01_71_09_05_03;
        "8": cols = 40'h36_49_49_49_36;
        "9": cols = 40'h06_49_49_29_1E;
        "A": cols = 40'h7E_11_11_11_7E;
        "B": cols = 40'h7F_49_49_49_36;
        "C": cols = 40'h3E_41_41_41_22;
        "D": cols = 40'h7F_41_41_22_1C;
        "E": cols = 40'h7F_49_49_49_41;
        "F": cols = 40'h7F_09_09_09_01;
        "G": cols = 40'h3E_41_49_49_7A;
        "H": cols = 40'h7F_08_08_08_7F;
        "I": cols = 40'h00_41_7F_41_00;
        "J": cols = 40'h20_40_41_3F_01;
        "K": cols = 40'h7F_08_14_22_41;
        "L": cols = 40'h7F_40_40_40_40;
        "M": cols = 40'h7F_02_0C_02_7F;
        "N": cols = 40'h7F_04_08_10_7F;
        "O": cols = 40'h3E_41_41_41_3E;
        "P": cols = 40'h7F_09_09_09_06;
        "Q": cols = 40'h3E_41_51_21_5E;
        "R": cols = 40'h7F_09_19_29_46;
        "S": cols = 40'h46_49_49_49_31;
        "T": cols = 40'h01_01_7F_01_01;
        "U": cols = 40'h3F_40_40_40_3F;
        "V": cols = 40'h1F_20_40_20_1F;
        "W": cols = 40'h7F_20_18_20_7F;
        "X": cols = 40'h63_14_08_14_63;
        "Y": cols = 40'h07_08_70_08_07;
        "Z": cols = 40'h61_51_49_45_43;
        "+": cols = 40'h08_08_3E_08_08;
        "-": cols = 40'h08_08_08_08_08;
        "*": cols = 40'h22_14_7F_14_22;
        "/": cols = 40'h20_10_08_04_02;
        "=": cols = 40'h14_14_14_14_14;
        ":": cols = 40'h00_36_36_00_00;
        ".": cols = 40'h00_60_60_00_00;
        "?": cols = 40'h02_01_51_09_06;
        " ": cols = 40'h00_00_00_00_00;
        default: cols = 40'h00_00_5F_00_00;  // anything else: vertical bar
      endcase
      return cols[39 - 8 * col -: 8];
    endfunction

    // color of panel pixel (x, y), y over the full 64 rows
    function logic [15:0] pixel(logic [5:0] x, logic [5:0] y);
      int unsigned cidx, offs, line, row, idx;
      logic [7:0] bits;
      if (x < LEFT_EDGE || x >= RIGHT_EDGE) return '0;
      cidx = (x - LEFT_EDGE) / CELL_PITCH;
      offs = (x - LEFT_EDGE) % CELL_PITCH;
      line = y / LINE_PITCH;
      row  = y % LINE_PITCH;
      if (offs >= GLYPH_COLS || row >= GLYPH_ROWS) return '0;
      idx = line * CELLS_PER_ROW + cidx;
      // text_len never exceeds capacity, so this also covers the bottom half
      if (idx >= text_len) return '0;
      bits = font_column(glyph_codes[idx], offs);
      return bits[row] ? ink : '0;
    endfunction

    // one accepted input item
    function void note(tpp_in_t it);
      tpp_out_t want;
      case (it.operation)
        OP_CLEAR: text_len = 0;
        OP_APPEND: begin
          // full text: append dropped
          if (text_len < TEXT_CAP) begin
            glyph_codes[text_len] = it.char_code;
            text_len++;
          end
        end
        OP_QUERY: begin
          want.top_pixel     = pixel(it.pixel_column, {1'b0, it.half_row});
          want.bottom_pixel  = pixel(it.pixel_column, {1'b1, it.half_row});
          want.frame_address = {it.half_row, it.pixel_column};
          pairs_due.push_back(want);
        end
        default: ;  // ignored op: no state change, no result
      endcase
    endfunction

    // one accepted result item
    task check(tpp_out_t got);
      tpp_out_t want;
      if (pairs_due.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pairs_due.pop_front();
      if (got.top_pixel !== want.top_pixel)
        report($sformatf("addr %0d top got %h want %h",
                         want.frame_address, got.top_pixel, want.top_pixel));
      if (got.bottom_pixel !== want.bottom_pixel)
        report($sformatf("addr %0d bottom got %h want %h",
                         want.frame_address, got.bottom_pixel, want.bottom_pixel));
      if (got.frame_address !== want.frame_address)
        report($sformatf("address got %0d want %0d",
                         got.frame_address, want.frame_address));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  tpp_in_t     in_item;
  logic        out_valid;
  logic        out_stall;
  tpp_out_t    out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  panel_scoreboard sb = new();

  // stimulus/receiver coordination
  logic        hold_req;    // asks the receiver for one long hold-off
  logic        burst_in;    // sender runs without gaps
  int unsigned sent;        // items sent that the block acts on
  string       font_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ+-*/=:.? ";

  text_panel_pixel_renderer #(
    .TEXT_CAPACITY(TEXT_CAP)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #(RUN_LIMIT_NS);
    $display("** text_panel_pixel_renderer: FAILED **");
    $finish;
  end

  // result monitor: sample at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_item);
  end

  // receiver: random stall before each result, bursts with none, and one
  // long hold-off on request so the pipe backs up into the input side
  initial begin
    int unsigned wait_n;
    int unsigned served;
    out_stall = 1'b0;
    served    = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        wait_n   = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (((served / 32) % 4) == 3) begin
        wait_n = 0;  // every fourth stretch of results runs without stalls
      end else begin
        wait_n = $urandom_range(0, MAX_GAP);
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  function automatic tpp_in_t item_of(logic [1:0] op, logic [7:0] code,
                                      logic [5:0] x, logic [4:0] y);
    tpp_in_t it;
    it.operation    = op;
    it.char_code    = code;
    it.pixel_column = x;
    it.half_row     = y;
    return it;
  endfunction

  function automatic tpp_in_t rand_item(logic [1:0] op);
    return item_of(op, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                   5'($urandom_range(0, 31)));
  endfunction

  // mostly font characters, the rest any code (lower case, zero, high codes)
  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 9) < 7)
      return font_chars[$urandom_range(0, font_chars.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one item after a random gap (none while burst_in is set); valid stays up between back-to-back
  // items so it never gets two updates in one step
  task automatic push(tpp_in_t it);
    int unsigned gap;
    gap = burst_in ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note(it);
    if (it.operation != OP_IGNORED) sent++;
  endtask

  task automatic query(logic [5:0] x, logic [4:0] y);
    push(item_of(OP_QUERY, 8'($urandom_range(0, 255)), x, y));
  endtask

  task automatic append(logic [7:0] code);
    push(item_of(OP_APPEND, code, 6'($urandom_range(0, 63)),
                 5'($urandom_range(0, 31))));
  endtask

  // sender pause: drop valid, wait out every pending result plus latency
  task automatic wait_drain();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // color write; only called with the block idle
  task automatic write_ink(logic [15:0] c);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    sb.set_ink(c);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // pages of text: a clear and a run of appends (often past capacity), or a
  // few appends to the current text, then queries with a little noise mixed in
  task automatic run_pages(int unsigned quota);
    int unsigned k, m, r;
    while (sent < quota) begin
      burst_in = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) != 0) begin
        push(rand_item(OP_CLEAR));
        k = $urandom_range(0, 40);
      end else begin
        k = $urandom_range(0, 3);  // grow the current text
      end
      repeat (k) append(pick_code());
      m = $urandom_range(5, 40);
      repeat (m) begin
        r = $urandom_range(0, 99);
        if (r < 4)      push(rand_item(OP_IGNORED));
        else if (r < 8) append(pick_code());
        else if (r < 9) push(rand_item(OP_CLEAR));
        else            push(rand_item(OP_QUERY));
      end
    end
  endtask

  initial begin
    logic [15:0] ink;
    int unsigned target;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    burst_in  = 1'b0;
    sent      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: margins, spacing row/column, bar glyph, space, past length
    write_ink(16'hFFFF);
    query(6'd0, 5'd0);               // empty text
    query(6'd63, 5'd31);             // top address
    append("H");                     // cell 0
    append(8'h00);                   // code zero: bar
    append(" ");                     // blank cell
    append("a");                     // lower case: bar
    append(8'hFF);                   // bar
    query(6'd2, 5'd0);               // H, lit
    query(6'd2, 5'd7);               // spacing row
    query(6'd7, 5'd3);               // spacing column
    query(6'd10, 5'd0);              // bar, lit
    query(6'd10, 5'd5);              // bar, gap in the stroke
    query(6'd14, 5'd0);              // space
    query(6'd1, 5'd0);               // left margin
    query(6'd62, 5'd0);              // right margin
    query(6'd22, 5'd6);              // lower case bar, lit
    query(6'd28, 5'd4);              // high code bar, lit
    query(6'd32, 5'd0);              // past text length
    push(rand_item(OP_IGNORED));
    push(rand_item(OP_CLEAR));
    query(6'd2, 5'd0);               // cleared
    wait_drain();

    // random phases, each with its own color
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       ink = 16'h0000;
        1:       ink = 16'h8000;
        2:       ink = 16'h0001;
        3:       ink = 16'($urandom_range(1, 16'hFFFE));
        default: ink = 16'hFFFF;
      endcase
      write_ink(ink);
      target = 20 + (TOTAL_ITEMS - 20) * (p + 1) / PHASES;
      if (p == 1) hold_req = 1'b1;   // receiver backs off, sender keeps going
      if (p == 3) begin
        run_pages((sent + target) / 2);
        wait_drain();                // sender pause mid phase
      end
      run_pages(target);
      wait_drain();
    end

    if (sb.errors == 0) begin
      $display("** text_panel_pixel_renderer: PASSED **");
    end else begin
      $display("** text_panel_pixel_renderer: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tpp_pkg.sv
rtl/tpp_ram.sv
rtl/tpp_lane.sv
rtl/tpp_merge.sv
rtl/text_panel_pixel_renderer.sv
tb/text_panel_pixel_renderer_tb.sv
